// ----- src/rtma_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtma_pkg
// Types, constants and helpers shared by the ring texture memory allocator.
// ----------------------------------------------------------------------------
package rtma_pkg;

  localparam int unsigned BLOCK_SLOTS = 63;
  localparam int unsigned ADDR_BITS  = 24;
  localparam int unsigned EDGE_LOG2  = 21;
  localparam int unsigned IDX_W      = $clog2(BLOCK_SLOTS);
  localparam int unsigned LINK_W     = 7;
  localparam int unsigned OWNER_W    = 16;
  localparam int unsigned SUM_W      = ADDR_BITS + 2;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [LINK_W-1:0] LINK_NONE = '1;

  // register select: paddr bit above the word offset
  localparam logic REG_LOW  = 1'b0;
  localparam logic REG_HIGH = 1'b1;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_EVICT = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HEAD_RD,
    S_HEAD_SUM,
    S_EDGE,
    S_FIT,
    S_WRAP_RD,
    S_WRAP_REL,
    S_WALK_RD,
    S_WALK_CMP,
    S_WALK_EVT,
    S_FINAL,
    S_FLUSH
  } state_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [ADDR_BITS-1:0] size;
    logic [OWNER_W-1:0]   owner;
  } in_item_t;

  typedef struct packed {
    kind_e                kind;
    logic [OWNER_W-1:0]   owner_res;
    logic [ADDR_BITS-1:0] address;
    logic [ADDR_BITS-1:0] size_res;
    logic [ADDR_BITS-1:0] bytes_in_use;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] low;
    logic [ADDR_BITS-1:0] high;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] size;
    logic [OWNER_W-1:0]   owner;
    logic                 present;
  } region_t;

  typedef struct packed {
    logic              link_re;
    logic [IDX_W-1:0]  link_raddr;
    logic              link_we;
    logic [IDX_W-1:0]  link_waddr;
    logic [LINK_W-1:0] link_wdata;
    logic              reg_re;
    logic [IDX_W-1:0]  reg_raddr;
    logic              reg_we;
    logic [IDX_W-1:0]  reg_waddr;
    region_t           reg_wdata;
    logic              clear;
  } store_req_t;

  typedef struct packed {
    logic [LINK_W-1:0] link_rdata;
    region_t           reg_rdata;
  } store_rsp_t;

  typedef struct packed {
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
    logic [SUM_W-1:0] c;
    logic             sub;
  } alu_op_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             gt;
    logic             lt;
  } alu_res_t;

  function automatic logic is_valid(input logic [LINK_W-1:0] idx);
    return idx < LINK_W'(BLOCK_SLOTS);
  endfunction

  // power-up link of an entry: chain to the next one, last entry ends the list
  function automatic logic [LINK_W-1:0] link_default(input logic [IDX_W-1:0] idx);
    logic [LINK_W-1:0] nxt;
    nxt = LINK_W'(idx) + LINK_W'(1);
    if (nxt < LINK_W'(BLOCK_SLOTS)) begin
      return nxt;
    end
    return LINK_NONE;
  endfunction

endpackage
`default_nettype wire

// ----- src/ring_texture_memory_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ring_texture_memory_allocator
// Circular allocator for a texture memory window with owner eviction reports.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  beat contents
//  in       to block   in_valid_i / in_stall_o    in_data_i: cmd, size, owner
//  out      from block out_valid_o / out_stall_i  out_data_o: kind, owner_res,
//                                                 address, size_res,
//                                                 bytes_in_use, last
//  cfg      to block   APB psel/penable/pready    low_address 0x0, high_address 0x4
//
// Flush: S_FLUSH registers its beat once the output is free. Allocation: the
// head read and sum, then on a non-empty list edge snap and fit; a wrap adds a
// read and release, each overlapped block a read, compare and (with an owner)
// evict step. The shared adder does one placement, overlap or byte-count step
// per cycle; the list store returns one entry per cycle. in_stall_o is high for
// the whole item; a stalled output beat halts the walk. After reset the used list
// is empty, the free list holds all blocks and the window spans 0x000000..0xFFFFFF.
// ----------------------------------------------------------------------------
module ring_texture_memory_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rtma_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rtma_pkg::res_t                 out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rtma_pkg::PADDR_W-1:0]   paddr,
  input  logic [rtma_pkg::PDATA_W-1:0]   pwdata,
  output logic [rtma_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic [rtma_pkg::ADDR_BITS-1:0] low_q;
  logic [rtma_pkg::ADDR_BITS-1:0] high_q;
  logic                           reg_wr;
  logic                           reg_sel;
  rtma_pkg::cfg_t                 cfg;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[rtma_pkg::PADDR_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '1;
    end else if (reg_wr) begin
      if (reg_sel == rtma_pkg::REG_HIGH) begin
        high_q <= pwdata[rtma_pkg::ADDR_BITS-1:0];
      end else begin
        low_q <= pwdata[rtma_pkg::ADDR_BITS-1:0];
      end
    end
  end

  assign prdata = (reg_sel == rtma_pkg::REG_LOW) ? rtma_pkg::PDATA_W'(low_q)
                                                 : rtma_pkg::PDATA_W'(high_q);

  assign cfg.low  = low_q;
  assign cfg.high = high_q;

  rtma_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ----- src/rtma_alu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtma_alu
// Shared adder/subtractor with compare against a third operand.
// ----------------------------------------------------------------------------
module rtma_alu (
  input  rtma_pkg::alu_op_t  op_i,
  output rtma_pkg::alu_res_t res_o
);

  logic [rtma_pkg::SUM_W-1:0] b_eff;
  logic [rtma_pkg::SUM_W-1:0] sum;

  // two's complement subtract: invert b, carry in
  assign b_eff = op_i.b ^ {rtma_pkg::SUM_W{op_i.sub}};
  assign sum   = op_i.a + b_eff + rtma_pkg::SUM_W'(op_i.sub);

  assign res_o.sum = sum;
  assign res_o.gt  = sum > op_i.c;
  assign res_o.lt  = sum < op_i.c;

endmodule
`default_nettype wire

// ----- src/rtma_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtma_store
// Block link store and region store, one write and one registered read each.
// Per-entry valid bits give the power-up contents until an entry is written.
// ----------------------------------------------------------------------------
module rtma_store (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rtma_pkg::store_req_t   req_i,
  output rtma_pkg::store_rsp_t   rsp_o
);

  logic [rtma_pkg::LINK_W-1:0]      link_mem [rtma_pkg::BLOCK_SLOTS];
  rtma_pkg::region_t                reg_mem  [rtma_pkg::BLOCK_SLOTS];
  logic [rtma_pkg::BLOCK_SLOTS-1:0] link_vld_q;
  logic [rtma_pkg::BLOCK_SLOTS-1:0] reg_vld_q;

  logic [rtma_pkg::LINK_W-1:0] link_rd_q;
  logic [rtma_pkg::IDX_W-1:0]  link_rd_idx_q;
  logic                        link_rd_vld_q;
  rtma_pkg::region_t           reg_rd_q;
  logic                        reg_rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.link_we) begin
      link_mem[req_i.link_waddr] <= req_i.link_wdata;
    end
    if (req_i.reg_we) begin
      reg_mem[req_i.reg_waddr] <= req_i.reg_wdata;
    end
    if (req_i.link_re) begin
      link_rd_q     <= link_mem[req_i.link_raddr];
      link_rd_idx_q <= req_i.link_raddr;
    end
    if (req_i.reg_re) begin
      reg_rd_q <= reg_mem[req_i.reg_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q    <= '0;
      reg_vld_q     <= '0;
      link_rd_vld_q <= 1'b0;
      reg_rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.clear) begin
        link_vld_q <= '0;
        reg_vld_q  <= '0;
      end else begin
        if (req_i.link_we) begin
          link_vld_q[req_i.link_waddr] <= 1'b1;
        end
        if (req_i.reg_we) begin
          reg_vld_q[req_i.reg_waddr] <= 1'b1;
        end
      end
      if (req_i.link_re) begin
        link_rd_vld_q <= link_vld_q[req_i.link_raddr];
      end
      if (req_i.reg_re) begin
        reg_rd_vld_q <= reg_vld_q[req_i.reg_raddr];
      end
    end
  end

  assign rsp_o.link_rdata = link_rd_vld_q ? link_rd_q
                                          : rtma_pkg::link_default(link_rd_idx_q);
  assign rsp_o.reg_rdata  = reg_rd_vld_q ? reg_rd_q : '0;

endmodule
`default_nettype wire

// ----- src/rtma_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtma_seq
// Allocation sequencer: placement, wrap, overlap walk, flush and result register.
// ----------------------------------------------------------------------------
module rtma_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtma_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rtma_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rtma_pkg::res_t     out_data_o
);

  rtma_pkg::state_e state_q, state_d;

  logic [rtma_pkg::LINK_W-1:0]    ff_q, ff_d;
  logic [rtma_pkg::LINK_W-1:0]    oldest_q, oldest_d;
  logic [rtma_pkg::LINK_W-1:0]    newest_q, newest_d;
  logic [rtma_pkg::LINK_W-1:0]    n_q, n_d;
  logic [rtma_pkg::LINK_W-1:0]    next_q, next_d;
  logic [rtma_pkg::LINK_W-1:0]    lff_q, lff_d;
  logic [rtma_pkg::ADDR_BITS-1:0] bytes_q, bytes_d;
  logic [rtma_pkg::ADDR_BITS-1:0] size_q, size_d;
  logic [rtma_pkg::OWNER_W-1:0]   owner_q, owner_d;
  logic [rtma_pkg::SUM_W-1:0]     addr_q, addr_d;
  rtma_pkg::res_t                 out_q, out_d;
  logic                           out_vld_q, out_vld_d;

  logic in_accept;
  logic out_free;
  logic out_load;
  logic bnd_cross;
  logic wrap;

  logic [rtma_pkg::SUM_W-1:0]  low_ext;
  logic [rtma_pkg::SUM_W-1:0]  bnd_addr;
  rtma_pkg::alu_op_t           alu_op;
  rtma_pkg::alu_res_t          alu_res;
  rtma_pkg::store_req_t        st_req;
  rtma_pkg::store_rsp_t        st_rsp;
  rtma_pkg::region_t           rd_reg;
  logic [rtma_pkg::LINK_W-1:0] rd_link;

  rtma_alu u_alu (
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  rtma_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (st_req),
    .rsp_o  (st_rsp)
  );

  assign rd_reg  = st_rsp.reg_rdata;
  assign rd_link = st_rsp.link_rdata;

  assign in_stall_o  = (state_q != rtma_pkg::S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign low_ext   = rtma_pkg::SUM_W'(cfg_i.low);
  // region end still below the top but in a higher 2 MB page: snap to that page
  assign bnd_cross = alu_res.lt &&
                     (alu_res.sum[rtma_pkg::SUM_W-1:rtma_pkg::EDGE_LOG2] >
                      addr_q[rtma_pkg::SUM_W-1:rtma_pkg::EDGE_LOG2]);
  assign bnd_addr  = {alu_res.sum[rtma_pkg::SUM_W-1:rtma_pkg::EDGE_LOG2],
                      {rtma_pkg::EDGE_LOG2{1'b0}}};
  // wrap when past the top, or fewer than two free blocks remain
  assign wrap      = alu_res.gt || !rtma_pkg::is_valid(ff_q) ||
                     !rtma_pkg::is_valid(lff_q);

  // shared adder operands
  always_comb begin
    alu_op.a   = addr_q;
    alu_op.b   = rtma_pkg::SUM_W'(size_q);
    alu_op.c   = rtma_pkg::SUM_W'(cfg_i.high);
    alu_op.sub = 1'b0;
    unique case (state_q)
      rtma_pkg::S_HEAD_SUM: begin
        alu_op.a = rtma_pkg::SUM_W'(rd_reg.start);
        alu_op.b = rtma_pkg::SUM_W'(rd_reg.size);
      end
      rtma_pkg::S_WALK_CMP: begin
        alu_op.c = rtma_pkg::SUM_W'(rd_reg.start);
      end
      rtma_pkg::S_WRAP_REL, rtma_pkg::S_WALK_EVT: begin
        alu_op.a   = rtma_pkg::SUM_W'(bytes_q);
        alu_op.b   = rtma_pkg::SUM_W'(rd_reg.size);
        alu_op.sub = 1'b1;
      end
      rtma_pkg::S_FINAL: begin
        alu_op.a = rtma_pkg::SUM_W'(bytes_q);
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtma_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = (in_data_i.cmd == rtma_pkg::CMD_FLUSH) ? rtma_pkg::S_FLUSH
                                                           : rtma_pkg::S_HEAD_RD;
        end
      end
      rtma_pkg::S_HEAD_RD:  state_d = rtma_pkg::S_HEAD_SUM;
      rtma_pkg::S_HEAD_SUM: begin
        state_d = rtma_pkg::is_valid(oldest_q) ? rtma_pkg::S_EDGE : rtma_pkg::S_FINAL;
      end
      rtma_pkg::S_EDGE:     state_d = rtma_pkg::S_FIT;
      rtma_pkg::S_FIT:      state_d = wrap ? rtma_pkg::S_WRAP_RD : rtma_pkg::S_WALK_RD;
      rtma_pkg::S_WRAP_RD:  state_d = rtma_pkg::S_WRAP_REL;
      rtma_pkg::S_WRAP_REL: begin
        if (!rd_reg.present || out_free) begin
          state_d = rtma_pkg::S_WALK_RD;
        end
      end
      rtma_pkg::S_WALK_RD: begin
        state_d = rtma_pkg::is_valid(next_q) ? rtma_pkg::S_WALK_CMP : rtma_pkg::S_FINAL;
      end
      rtma_pkg::S_WALK_CMP: begin
        if (!alu_res.gt) begin
          state_d = rtma_pkg::S_FINAL;
        end else if (rd_reg.present) begin
          state_d = rtma_pkg::S_WALK_EVT;
        end else begin
          state_d = rtma_pkg::S_WALK_RD;
        end
      end
      rtma_pkg::S_WALK_EVT: begin
        if (out_free) begin
          state_d = rtma_pkg::S_WALK_RD;
        end
      end
      rtma_pkg::S_FINAL, rtma_pkg::S_FLUSH: begin
        if (out_free) begin
          state_d = rtma_pkg::S_IDLE;
        end
      end
      default: state_d = rtma_pkg::S_IDLE;
    endcase
  end

  // datapath, store requests, result register load
  always_comb begin
    ff_d     = ff_q;
    oldest_d = oldest_q;
    newest_d = newest_q;
    n_d      = n_q;
    next_d   = next_q;
    lff_d    = lff_q;
    bytes_d  = bytes_q;
    size_d   = size_q;
    owner_d  = owner_q;
    addr_d   = addr_q;
    out_d    = out_q;
    out_load = 1'b0;
    st_req   = '0;

    unique case (state_q)
      rtma_pkg::S_IDLE: begin
        if (in_accept) begin
          size_d  = in_data_i.size;
          owner_d = in_data_i.owner;
        end
      end
      rtma_pkg::S_HEAD_RD: begin
        st_req.link_re    = rtma_pkg::is_valid(ff_q);
        st_req.link_raddr = ff_q[rtma_pkg::IDX_W-1:0];
        st_req.reg_re     = rtma_pkg::is_valid(newest_q);
        st_req.reg_raddr  = newest_q[rtma_pkg::IDX_W-1:0];
      end
      rtma_pkg::S_HEAD_SUM: begin
        lff_d = rd_link;
        if (!rtma_pkg::is_valid(oldest_q)) begin
          // empty list: first block from the free list, placed at the bottom
          n_d    = ff_q;
          next_d = rtma_pkg::LINK_NONE;
          addr_d = low_ext;
          if (rtma_pkg::is_valid(ff_q)) begin
            ff_d     = rd_link;
            oldest_d = ff_q;
            newest_d = ff_q;
          end
        end else begin
          addr_d            = rtma_pkg::is_valid(newest_q) ? alu_res.sum : low_ext;
          st_req.link_re    = rtma_pkg::is_valid(newest_q);
          st_req.link_raddr = newest_q[rtma_pkg::IDX_W-1:0];
        end
      end
      rtma_pkg::S_EDGE: begin
        if (bnd_cross) begin
          addr_d = bnd_addr;
        end
      end
      rtma_pkg::S_FIT: begin
        if (wrap) begin
          n_d      = oldest_q;
          newest_d = oldest_q;
          addr_d   = low_ext;
        end else begin
          // splice the free head in after the newest block
          n_d               = ff_q;
          ff_d              = lff_q;
          newest_d          = ff_q;
          next_d            = rd_link;
          st_req.link_we    = rtma_pkg::is_valid(newest_q);
          st_req.link_waddr = newest_q[rtma_pkg::IDX_W-1:0];
          st_req.link_wdata = ff_q;
        end
      end
      rtma_pkg::S_WRAP_RD: begin
        st_req.link_re    = 1'b1;
        st_req.link_raddr = oldest_q[rtma_pkg::IDX_W-1:0];
        st_req.reg_re     = 1'b1;
        st_req.reg_raddr  = oldest_q[rtma_pkg::IDX_W-1:0];
      end
      rtma_pkg::S_WRAP_REL: begin
        next_d = rd_link;
        // the reused block is rewritten at the end, no need to clear it here
        if (rd_reg.present && out_free) begin
          bytes_d  = alu_res.sum[rtma_pkg::ADDR_BITS-1:0];
          out_load = 1'b1;
          out_d    = '{kind:         rtma_pkg::KIND_EVICT,
                       owner_res:    rd_reg.owner,
                       address:      rd_reg.start,
                       size_res:     rd_reg.size,
                       bytes_in_use: alu_res.sum[rtma_pkg::ADDR_BITS-1:0],
                       last:         1'b0};
        end
      end
      rtma_pkg::S_WALK_RD: begin
        st_req.link_re    = rtma_pkg::is_valid(next_q);
        st_req.link_raddr = next_q[rtma_pkg::IDX_W-1:0];
        st_req.reg_re     = rtma_pkg::is_valid(next_q);
        st_req.reg_raddr  = next_q[rtma_pkg::IDX_W-1:0];
      end
      rtma_pkg::S_WALK_CMP: begin
        if (alu_res.gt) begin
          // overlapped: push onto the free list; region entry is rewritten
          // before it can be read again
          st_req.link_we    = 1'b1;
          st_req.link_waddr = next_q[rtma_pkg::IDX_W-1:0];
          st_req.link_wdata = ff_q;
          ff_d              = next_q;
          next_d            = rd_link;
        end
      end
      rtma_pkg::S_WALK_EVT: begin
        if (out_free) begin
          bytes_d  = alu_res.sum[rtma_pkg::ADDR_BITS-1:0];
          out_load = 1'b1;
          out_d    = '{kind:         rtma_pkg::KIND_EVICT,
                       owner_res:    rd_reg.owner,
                       address:      rd_reg.start,
                       size_res:     rd_reg.size,
                       bytes_in_use: alu_res.sum[rtma_pkg::ADDR_BITS-1:0],
                       last:         1'b0};
        end
      end
      rtma_pkg::S_FINAL: begin
        if (out_free) begin
          if (rtma_pkg::is_valid(n_q)) begin
            st_req.reg_we     = 1'b1;
            st_req.reg_waddr  = n_q[rtma_pkg::IDX_W-1:0];
            st_req.reg_wdata  = '{start:   addr_q[rtma_pkg::ADDR_BITS-1:0],
                                  size:    size_q,
                                  owner:   owner_q,
                                  present: 1'b1};
            st_req.link_we    = 1'b1;
            st_req.link_waddr = n_q[rtma_pkg::IDX_W-1:0];
            st_req.link_wdata = rtma_pkg::is_valid(next_q) ? next_q
                                                           : rtma_pkg::LINK_NONE;
          end
          bytes_d  = alu_res.sum[rtma_pkg::ADDR_BITS-1:0];
          out_load = 1'b1;
          out_d    = '{kind:         rtma_pkg::KIND_ALLOC,
                       owner_res:    owner_q,
                       address:      addr_q[rtma_pkg::ADDR_BITS-1:0],
                       size_res:     size_q,
                       bytes_in_use: alu_res.sum[rtma_pkg::ADDR_BITS-1:0],
                       last:         1'b1};
        end
      end
      rtma_pkg::S_FLUSH: begin
        if (out_free) begin
          st_req.clear = 1'b1;
          ff_d         = '0;
          oldest_d     = rtma_pkg::LINK_NONE;
          newest_d     = rtma_pkg::LINK_NONE;
          bytes_d      = '0;
          out_load     = 1'b1;
          out_d        = '{kind:         rtma_pkg::KIND_FLUSH,
                           owner_res:    '0,
                           address:      '0,
                           size_res:     '0,
                           bytes_in_use: '0,
                           last:         1'b1};
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      out_vld_d = 1'b1;
    end else begin
      out_vld_d = out_vld_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rtma_pkg::S_IDLE;
      ff_q      <= '0;
      oldest_q  <= rtma_pkg::LINK_NONE;
      newest_q  <= rtma_pkg::LINK_NONE;
      n_q       <= rtma_pkg::LINK_NONE;
      next_q    <= rtma_pkg::LINK_NONE;
      bytes_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ff_q      <= ff_d;
      oldest_q  <= oldest_d;
      newest_q  <= newest_d;
      n_q       <= n_d;
      next_q    <= next_d;
      bytes_q   <= bytes_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q  <= size_d;
    owner_q <= owner_d;
    addr_q  <= addr_d;
    lff_q   <= lff_d;
    out_q   <= out_d;
  end

  a_list_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rtma_pkg::is_valid(oldest_q) |-> rtma_pkg::is_valid(newest_q))
    else $error("used list has an oldest block but no newest block");

  a_walk_skips_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rtma_pkg::S_WALK_CMP |-> next_q != n_q)
    else $error("overlap walk reached the block being placed");

  a_free_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rtma_pkg::S_WALK_RD |-> ff_q != newest_q)
    else $error("free list head is the newest used block");

  a_place_relinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_req.reg_we |-> st_req.link_we && st_req.reg_waddr == st_req.link_waddr)
    else $error("placed region written without relinking its block");

endmodule
`default_nettype wire
